### rtl/core/pic_pkg.sv
// shared types and constants for the point-in-polygon crossing test
// no dependencies; used by the ring cell, the edge unit, the top level and the testbench

package pic_pkg;

	// default sizes
	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_COORD_BITS   = 16;

	// fixed field widths
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;

	// item kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DRAIN,
		ST_FIN
	} pic_state_t;

	// edge unit status toward the sequencer
	typedef struct packed {
		logic hit;
		logic valid;
		logic busy;
	} edge_stat_t;

endpackage

### rtl/core/point_in_polygon_crossing.sv
// top level of the crossing-number point-in-polygon test
// depends on pic_pkg, pic_cell (vertex ring) and pic_edge (edge test)
//
// usage:
//   input channel (in_valid / in_stall) takes one word per item: kind 0 loads
//   point_x / point_y into ring slot vertex_index (slots beyond the ring are
//   dropped), kind 1 queries the point (point_x, point_y).
//   a load gives no result word.
//   a query rotates the vertex ring one cell per cycle through the edge unit:
//   it walks the whole ring, drains the edge pipeline (sooner when the last
//   crossing candidate came early) and loads the output register; the next
//   item can be taken from the cycle after the output register is loaded.
//   the ring length sets the walk, not vertex_count.
//   in_stall is high for the whole query.
//   output channel (out_valid / out_stall) gives inside_res and crossings
//   (count mod 128) once per query from an output register; a new item is
//   taken while that word waits, and a finished query holds until it is free.
//   config channel (cfg_valid / cfg_ready) writes vertex_count, always ready;
//   write it only between items. counts above MAX_VERTICES act as the maximum.
//   reset clears vertex_count, the sequencer and out_valid; the ring contents
//   stay undefined until loaded.

module point_in_polygon_crossing #(
	parameter int MAX_VERTICES = pic_pkg::DEF_MAX_VERTICES,
	parameter int COORD_BITS   = pic_pkg::DEF_COORD_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// config
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pic_pkg::CNT_W-1:0]      cfg_data,
	// input items
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           kind,
	input  logic [pic_pkg::IDX_W-1:0]      vertex_index,
	input  logic signed [COORD_BITS-1:0]   point_x,
	input  logic signed [COORD_BITS-1:0]   point_y,
	// results
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           inside_res,
	output logic [pic_pkg::CNT_W-1:0]      crossings
);

	localparam int VW     = 2 * COORD_BITS;
	localparam int TW     = $clog2(MAX_VERTICES + 1);
	localparam int CMP_W  = (TW > pic_pkg::CNT_W) ? TW : pic_pkg::CNT_W;
	localparam int SLOT_W = (MAX_VERTICES > (1 << pic_pkg::IDX_W)) ?
		$clog2(MAX_VERTICES) : pic_pkg::IDX_W;

	pic_pkg::pic_state_t state_q, state_d;
	pic_pkg::edge_stat_t stat;

	logic [pic_pkg::CNT_W-1:0]    vertex_count_q;
	logic [TW-1:0]                t_q;
	logic [TW-1:0]                n_q;
	logic [TW-1:0]                n_sat;
	logic [VW-1:0]                first_q;
	logic [VW-1:0]                prev_q;
	logic signed [COORD_BITS-1:0] px_q, py_q;
	logic [pic_pkg::CNT_W-1:0]    count_q;
	logic                         out_valid_q;
	logic                         inside_res_q;
	logic [pic_pkg::CNT_W-1:0]    crossings_q;

	logic          in_take, load_go, query_go;
	logic          walk, shift_en, edge_valid, fin_load;
	logic [VW-1:0] vert_a;
	logic [VW-1:0] ring [MAX_VERTICES];
	logic [SLOT_W-1:0] slot_ext;

	// handshakes
	assign cfg_ready = 1'b1;
	assign in_take   = in_valid && !in_stall;
	assign load_go   = in_take && (kind == pic_pkg::KIND_LOAD);
	assign query_go  = in_take && (kind == pic_pkg::KIND_QUERY);
	assign slot_ext  = SLOT_W'(vertex_index);

	// vertex count, saturated to the ring length
	always_comb begin
		if (CMP_W'(vertex_count_q) > CMP_W'(MAX_VERTICES)) begin
			n_sat = TW'(MAX_VERTICES);
		end else begin
			n_sat = TW'(vertex_count_q);
		end
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			vertex_count_q <= cfg_data;
		end
	end

	// vertex ring, head is cell 0
	for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_ring
		localparam int NXT = (k + 1) % MAX_VERTICES;
		pic_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk      (clk),
			.load_en  (load_go && (slot_ext == SLOT_W'(k))),
			.load_data({point_y, point_x}),
			.shift_en (shift_en),
			.shift_in (ring[NXT]),
			.vert     (ring[k])
		);
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pic_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		walk     = 1'b0;
		fin_load = 1'b0;
		case (state_q)
			pic_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (query_go) begin
					state_d = pic_pkg::ST_WALK;
				end
			end
			pic_pkg::ST_WALK: begin
				walk = 1'b1;
				if (t_q == TW'(MAX_VERTICES)) begin
					state_d = pic_pkg::ST_DRAIN;
				end
			end
			pic_pkg::ST_DRAIN: begin
				if (!stat.busy) begin
					state_d = pic_pkg::ST_FIN;
				end
			end
			pic_pkg::ST_FIN: begin
				if (!out_valid_q || !out_stall) begin
					fin_load = 1'b1;
					state_d  = pic_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pic_pkg::ST_IDLE;
			end
		endcase
	end

	// edge selection: vertex t against vertex t-1, closing edge uses vertex 0
	assign shift_en   = walk && (t_q != TW'(MAX_VERTICES));
	assign edge_valid = walk && (t_q != '0) && (t_q <= n_q);
	assign vert_a     = (t_q == n_q) ? first_q : ring[0];

	// walk counter and query registers, counter stops at the ring length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q     <= '0;
			count_q <= '0;
		end else begin
			if (query_go) begin
				t_q     <= '0;
				count_q <= '0;
			end else begin
				if (shift_en) begin
					t_q <= t_q + 1'b1;
				end
				if (stat.valid && stat.hit) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// query point, count and vertex history
	always_ff @(posedge clk) begin
		if (query_go) begin
			px_q <= point_x;
			py_q <= point_y;
			n_q  <= n_sat;
		end
		if (walk) begin
			prev_q <= ring[0];
			if (t_q == '0) begin
				first_q <= ring[0];
			end
		end
	end

	pic_edge #(
		.COORD_BITS(COORD_BITS)
	) u_edge (
		.clk       (clk),
		.arst_n    (arst_n),
		.edge_valid(edge_valid),
		.vert_a    (vert_a),
		.vert_b    (prev_q),
		.px        (px_q),
		.py        (py_q),
		.stat      (stat)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			inside_res_q <= count_q[0];
			crossings_q  <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign inside_res = inside_res_q;
	assign crossings  = crossings_q;

`ifndef SYNTHESIS
	// result taken only after the edge pipeline has drained
	a_fin_drained: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |-> !stat.busy)
		else $error("result captured with edges in flight");

	// no edge in flight while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pic_pkg::ST_IDLE) |-> !stat.busy)
		else $error("edge unit busy while idle");

	// a query starts a fresh walk
	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		query_go |=> (state_q == pic_pkg::ST_WALK) && (t_q == '0) && (count_q == '0))
		else $error("query did not start a fresh walk");

	// walk counter never passes the ring length
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		t_q <= TW'(MAX_VERTICES))
		else $error("walk counter overran the ring");
`endif

endmodule

### rtl/core/pic_cell.sv
// one ring cell: holds one polygon vertex {y, x}
// loaded directly by slot, shifts to its neighbor while a query walks the ring

module pic_cell #(
	parameter int COORD_BITS = pic_pkg::DEF_COORD_BITS
) (
	input  logic                    clk,
	input  logic                    load_en,
	input  logic [2*COORD_BITS-1:0] load_data,
	input  logic                    shift_en,
	input  logic [2*COORD_BITS-1:0] shift_in,
	output logic [2*COORD_BITS-1:0] vert
);

	logic [2*COORD_BITS-1:0] vert_q;

	// vertex storage, undefined until loaded
	always_ff @(posedge clk) begin
		if (load_en) begin
			vert_q <= load_data;
		end else if (shift_en) begin
			vert_q <= shift_in;
		end
	end

	assign vert = vert_q;

endmodule

### rtl/core/pic_edge.sv
// edge crossing test, three stages: differences, products, compare
// depends on pic_pkg for the status struct

module pic_edge #(
	parameter int COORD_BITS = pic_pkg::DEF_COORD_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         edge_valid,
	input  logic [2*COORD_BITS-1:0]      vert_a,
	input  logic [2*COORD_BITS-1:0]      vert_b,
	input  logic signed [COORD_BITS-1:0] px,
	input  logic signed [COORD_BITS-1:0] py,
	output pic_pkg::edge_stat_t          stat
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * DW;

	logic signed [COORD_BITS-1:0] xa, ya, xb, yb;
	logic signed [COORD_BITS-1:0] xlo, ylo, xhi, yhi;
	logic                         cand;

	logic signed [DW-1:0] d_a_s1, d_b_s1, d_c_s1, d_d_s1;
	logic                 vld_s1;
	logic signed [PW-1:0] prod_l_s2, prod_r_s2;
	logic                 vld_s2;
	logic                 hit_s3;
	logic                 vld_s3;

	// unpack endpoints and apply the half-open rule
	always_comb begin
		xa   = $signed(vert_a[COORD_BITS-1:0]);
		ya   = $signed(vert_a[2*COORD_BITS-1:COORD_BITS]);
		xb   = $signed(vert_b[COORD_BITS-1:0]);
		yb   = $signed(vert_b[2*COORD_BITS-1:COORD_BITS]);
		cand = (ya > py) != (yb > py);
		// order endpoints so that the low one comes first
		if (ya > yb) begin
			xlo = xb;
			ylo = yb;
			xhi = xa;
			yhi = ya;
		end else begin
			xlo = xa;
			ylo = ya;
			xhi = xb;
			yhi = yb;
		end
	end

	// valid bits of the three stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= edge_valid && cand;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// stage 1: differences
	always_ff @(posedge clk) begin
		d_a_s1 <= DW'(py) - DW'(ylo);
		d_b_s1 <= DW'(xhi) - DW'(xlo);
		d_c_s1 <= DW'(px) - DW'(xlo);
		d_d_s1 <= DW'(yhi) - DW'(ylo);
	end

	// stage 2: cross products
	always_ff @(posedge clk) begin
		prod_l_s2 <= PW'(d_a_s1) * PW'(d_b_s1);
		prod_r_s2 <= PW'(d_c_s1) * PW'(d_d_s1);
	end

	// stage 3: crossing strictly left of the point
	always_ff @(posedge clk) begin
		hit_s3 <= prod_l_s2 < prod_r_s2;
	end

	assign stat.hit   = hit_s3;
	assign stat.valid = vld_s3;
	assign stat.busy  = vld_s1 || vld_s2 || vld_s3;

endmodule

### test/tb_point_in_polygon_crossing.sv
// self-checking testbench for point_in_polygon_crossing: vertex loads, point queries
// and vertex_count writes, checked against an in-bench crossing-count predictor
// depends on pic_pkg and the point_in_polygon_crossing rtl

module tb_point_in_polygon_crossing;

	localparam int MAXV  = pic_pkg::DEF_MAX_VERTICES;
	localparam int CB    = pic_pkg::DEF_COORD_BITS;
	localparam int CNT_W = pic_pkg::CNT_W;
	localparam int IDX_W = pic_pkg::IDX_W;
	// a query walks the whole ring plus drain, so this covers any word in flight
	localparam int SETTLE = MAXV + 16;
	localparam int RANDOM_ITEMS = 700;

	typedef logic signed [CB-1:0] coord_t;

	typedef struct packed {
		coord_t y;
		coord_t x;
	} vertex_t;

	typedef struct packed {
		logic             odd;
		logic [CNT_W-1:0] crossings;
	} answer_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_QUERY,
		OP_SETCNT
	} plan_op_t;

	// value is the vertex_count for OP_SETCNT, the known crossing count for typed queries
	typedef struct packed {
		plan_op_t         op;
		logic [IDX_W-1:0] slot;
		coord_t           x;
		coord_t           y;
		logic             typed;
		logic [CNT_W-1:0] value;
	} plan_row_t;

	localparam int PLAN_LEN = 25;

	logic             clk;
	logic             arst_n;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data;
	logic             in_valid;
	logic             in_stall;
	logic             kind;
	logic [IDX_W-1:0] vertex_index;
	coord_t           point_x;
	coord_t           point_y;
	logic             out_valid;
	logic             out_stall;
	logic             inside_res;
	logic [CNT_W-1:0] crossings;

	// mirror of the block state
	vertex_t          ring_model [MAXV];
	logic [CNT_W-1:0] active_vertices;

	answer_t awaited_answers [$];
	int      mismatch_cnt;
	bit      calm;
	int      hold_left;

	plan_row_t directed_plan [PLAN_LEN] = '{
		// empty polygon right after reset: no edges at all
		'{OP_SETCNT, 6'd0, 16'sd0, 16'sd0, 1'b0, 7'd0},
		'{OP_QUERY, 6'd0, 16'sd0, 16'sd0, 1'b1, 7'd0},
		'{OP_QUERY, 6'd63, -16'sd32768, 16'sd32767, 1'b1, 7'd0},
		// axis-aligned square
		'{OP_LOAD, 6'd0, -16'sd100, -16'sd100, 1'b0, 7'd0},
		'{OP_LOAD, 6'd1, 16'sd100, -16'sd100, 1'b0, 7'd0},
		'{OP_LOAD, 6'd2, 16'sd100, 16'sd100, 1'b0, 7'd0},
		'{OP_LOAD, 6'd3, -16'sd100, 16'sd100, 1'b0, 7'd0},
		'{OP_SETCNT, 6'd0, 16'sd0, 16'sd0, 1'b0, 7'd4},
		'{OP_QUERY, 6'd21, 16'sd0, 16'sd0, 1'b0, 7'd0},
		'{OP_QUERY, 6'd42, 16'sd200, 16'sd0, 1'b0, 7'd0},
		'{OP_QUERY, 6'd0, -16'sd200, 16'sd0, 1'b0, 7'd0},
		// points on corners and on edges, incl. the horizontal ones
		'{OP_QUERY, 6'd1, 16'sd100, 16'sd100, 1'b0, 7'd0},
		'{OP_QUERY, 6'd2, -16'sd100, -16'sd100, 1'b0, 7'd0},
		'{OP_QUERY, 6'd4, 16'sd0, -16'sd100, 1'b0, 7'd0},
		'{OP_QUERY, 6'd8, -16'sd100, 16'sd0, 1'b0, 7'd0},
		'{OP_QUERY, 6'd16, 16'sd32767, 16'sd32767, 1'b0, 7'd0},
		'{OP_QUERY, 6'd32, -16'sd32768, -16'sd32768, 1'b0, 7'd0},
		// full-range square, widest products
		'{OP_LOAD, 6'd0, -16'sd32768, -16'sd32768, 1'b0, 7'd0},
		'{OP_LOAD, 6'd1, 16'sd32767, -16'sd32768, 1'b0, 7'd0},
		'{OP_LOAD, 6'd2, 16'sd32767, 16'sd32767, 1'b0, 7'd0},
		'{OP_LOAD, 6'd3, -16'sd32768, 16'sd32767, 1'b0, 7'd0},
		'{OP_QUERY, 6'd63, 16'sd32766, 16'sd0, 1'b0, 7'd0},
		'{OP_QUERY, 6'd0, -16'sd32768, 16'sd0, 1'b0, 7'd0},
		// two-vertex polygon: both edges are the same segment
		'{OP_SETCNT, 6'd0, 16'sd0, 16'sd0, 1'b0, 7'd2},
		'{OP_QUERY, 6'd5, 16'sd0, 16'sd0, 1'b0, 7'd0}
	};

	point_in_polygon_crossing i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.vertex_index (vertex_index),
		.point_x      (point_x),
		.point_y      (point_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.inside_res   (inside_res),
		.crossings    (crossings)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	initial begin
		#2000000;
		$display("tb_point_in_polygon_crossing NOT OK");
		$finish;
	end

	// half-open rule: one endpoint strictly above py, crossing x strictly left of px
	function automatic bit edge_crossed(vertex_t a, vertex_t b, longint px, longint py);
		longint x1, y1, x2, y2, t;
		x1 = longint'(a.x);
		y1 = longint'(a.y);
		x2 = longint'(b.x);
		y2 = longint'(b.y);
		if ((y1 > py) == (y2 > py))
			return 1'b0;
		if (y1 > y2) begin
			t = x1; x1 = x2; x2 = t;
			t = y1; y1 = y2; y2 = t;
		end
		return (py - y1) * (x2 - x1) < (px - x1) * (y2 - y1);
	endfunction

	// walk every edge from vertex i back to vertex i-1, wrapping at the start
	function automatic answer_t count_crossings(coord_t px, coord_t py);
		int n, hits, prev;
		answer_t a;
		n = (active_vertices > MAXV) ? MAXV : int'(active_vertices);
		hits = 0;
		for (int i = 0; i < n; i++) begin
			prev = (i == 0) ? n - 1 : i - 1;
			if (edge_crossed(ring_model[i], ring_model[prev], longint'(px), longint'(py)))
				hits++;
		end
		a.crossings = hits[CNT_W-1:0];
		a.odd       = hits[0];
		return a;
	endfunction

	// mostly no gap, some short ones, a few long; none while calm
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic coord_t pick_coord(int spread);
		int r;
		case (spread)
			0: return coord_t'($urandom_range(0, 80) - 40);
			1: return coord_t'($urandom_range(0, 4000) - 2000);
			2: return coord_t'($urandom);
			default: begin
				r = $urandom_range(0, 3);
				case (r)
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh7ffe;
					default: return coord_t'($urandom);
				endcase
			end
		endcase
	endfunction

	function automatic void flag_mismatch(string what);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("mismatch: %s", what);
	endfunction

	// offer one word, wait for it to be taken, then predict
	task automatic send_item(logic k, logic [IDX_W-1:0] slot, coord_t x, coord_t y,
			bit typed, logic [CNT_W-1:0] typed_cnt);
		int gap;
		answer_t want;
		gap = idle_len();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		vertex_index <= slot;
		point_x      <= x;
		point_y      <= y;
		do @(posedge clk); while (in_stall);
		if (k == pic_pkg::KIND_LOAD) begin
			ring_model[slot] = {y, x};
		end else begin
			if (typed) begin
				want.odd       = typed_cnt[0];
				want.crossings = typed_cnt;
			end else begin
				want = count_crossings(x, y);
			end
			awaited_answers.push_back(want);
		end
	endtask

	// drop valid on the falling edge right after the last acceptance
	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic wait_answers();
		while (awaited_answers.size() != 0)
			@(posedge clk);
	endtask

	// register write only with the block idle
	task automatic write_vertex_count(logic [CNT_W-1:0] v);
		release_input();
		wait_answers();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		active_vertices = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// calm stretches with no idling on either side
	initial begin
		calm = 1'b0;
		forever begin
			repeat ($urandom_range(100, 1500)) @(posedge clk);
			calm = ~calm;
		end
	end

	// result side stall
	initial begin
		out_stall = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= 1'b0;
				hold_left = idle_len();
			end
		end
	end

	// result check against the oldest expectation
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_answers.size() == 0) begin
				flag_mismatch($sformatf("unexpected word inside_res=%0b crossings=%0d",
					inside_res, crossings));
			end else begin
				want = awaited_answers.pop_front();
				if (inside_res !== want.odd)
					flag_mismatch($sformatf("inside_res expected %0b got %0b",
						want.odd, inside_res));
				if (crossings !== want.crossings)
					flag_mismatch($sformatf("crossings expected %0d got %0d",
						want.crossings, crossings));
			end
		end
	end

	// stimulus
	initial begin
		int phase_counts [10] = '{64, 3, 127, 0, 4, 65, 1, 2, 33, 64};
		int random_items, phase, n_used, spread, r, rounds;
		logic [CNT_W-1:0] v;
		coord_t qx, qy;

		mismatch_cnt    = 0;
		active_vertices = '0;
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		kind            = pic_pkg::KIND_LOAD;
		vertex_index    = '0;
		point_x         = '0;
		point_y         = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (directed_plan[i]) begin
			case (directed_plan[i].op)
				OP_SETCNT: write_vertex_count(directed_plan[i].value);
				OP_LOAD: send_item(pic_pkg::KIND_LOAD, directed_plan[i].slot,
					directed_plan[i].x, directed_plan[i].y, 1'b0, '0);
				default: send_item(pic_pkg::KIND_QUERY, directed_plan[i].slot,
					directed_plan[i].x, directed_plan[i].y, directed_plan[i].typed,
					directed_plan[i].value);
			endcase
		end

		// random phases: set a count, load a whole polygon, then query it with
		// occasional vertex rewrites; the first phase fills every slot so any
		// later count, saturated ones included, reads written vertices only
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			v = (phase < 10) ? CNT_W'(phase_counts[phase]) : CNT_W'($urandom_range(0, 127));
			phase++;
			write_vertex_count(v);
			n_used = (v > MAXV) ? MAXV : int'(v);
			spread = $urandom_range(0, 3);
			for (int s = 0; s < n_used; s++)
				send_item(pic_pkg::KIND_LOAD, IDX_W'(s), pick_coord(spread),
					pick_coord(spread), 1'b0, '0);
			random_items += n_used;
			rounds = $urandom_range(15, 40);
			for (int j = 0; j < rounds; j++) begin
				r = $urandom_range(0, 99);
				if (r < 80) begin
					// points on and next to vertex coordinates hit the boundary cases
					if (n_used > 0 && $urandom_range(0, 3) == 0) begin
						qx = ring_model[$urandom_range(0, n_used - 1)].x;
						qy = ring_model[$urandom_range(0, n_used - 1)].y;
						if ($urandom_range(0, 1))
							qx = coord_t'(qx + $urandom_range(0, 2) - 1);
					end else begin
						qx = pick_coord(($urandom_range(0, 9) == 0) ? 2 : spread);
						qy = pick_coord(($urandom_range(0, 9) == 0) ? 2 : spread);
					end
					send_item(pic_pkg::KIND_QUERY, IDX_W'($urandom_range(0, MAXV - 1)),
						qx, qy, 1'b0, '0);
					random_items++;
				end else if (r < 96) begin
					send_item(pic_pkg::KIND_LOAD, IDX_W'($urandom_range(0, MAXV - 1)),
						pick_coord(spread), pick_coord(spread), 1'b0, '0);
					random_items++;
				end else begin
					// hold off until the block has answered everything
					release_input();
					wait_answers();
				end
			end
		end

		release_input();
		wait_answers();
		repeat (SETTLE) @(posedge clk);
		if (mismatch_cnt == 0 && awaited_answers.size() == 0)
			$display("tb_point_in_polygon_crossing OK");
		else
			$display("tb_point_in_polygon_crossing NOT OK");
		$finish;
	end

endmodule
